/* design/cpl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpl_pkg
// shared types, constants and codes of the code point to pinyin lookup
// ----------------------------------------------------------------------------
package cpl_pkg;

    localparam int DENSE_DEPTH_DEF    = 16384;
    localparam int SPARSE_DEPTH_DEF   = 8192;
    localparam int EXTRA_DEPTH_DEF    = 4096;
    localparam int EXT_DEPTH_DEF      = 4096;
    localparam int DENSE_FLAG_BIT_DEF = 15;

    localparam int PAGE_DEPTH = 256;
    localparam logic [20:0] SPECIAL_POINT = 21'h30EDD;
    localparam logic [4:0]  EXT_PLANE     = 5'd2;

    // table identifiers carried by write items
    localparam logic [2:0] TBL_OFFSETS    = 3'd0;
    localparam logic [2:0] TBL_COUNTS     = 3'd1;
    localparam logic [2:0] TBL_DENSE      = 3'd2;
    localparam logic [2:0] TBL_SPARSE_LOW = 3'd3;
    localparam logic [2:0] TBL_SPARSE_PY  = 3'd4;
    localparam logic [2:0] TBL_EXTRA      = 3'd5;
    localparam logic [2:0] TBL_EXT        = 3'd6;

    // register indexes
    localparam logic [2:0] REG_PAGE_BASE  = 3'd0;
    localparam logic [2:0] REG_PAGE_TOTAL = 3'd1;
    localparam logic [2:0] REG_EXTRA_USED = 3'd2;
    localparam logic [2:0] REG_EXT_USED   = 3'd3;
    localparam logic [2:0] REG_SPECIAL    = 3'd4;

    // classified item handed from front to back
    typedef struct packed {
        logic        is_write;
        logic [2:0]  table_id;
        logic [13:0] table_addr;
        logic [31:0] table_word;
        logic [20:0] codepoint;
    } cpl_item_t;

endpackage
`default_nettype wire

/* design/cpl_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpl_front
// two-entry input queue feeding the lookup engine
// ----------------------------------------------------------------------------
module cpl_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire cpl_pkg::cpl_item_t  in_item,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output cpl_pkg::cpl_item_t       q_item
);

    cpl_pkg::cpl_item_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

/* design/cpl_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpl_back
// table memories and the sequencer that runs page, dense and binary searches
// ----------------------------------------------------------------------------
module cpl_back #(
    parameter int DENSE_DEPTH    = cpl_pkg::DENSE_DEPTH_DEF,
    parameter int SPARSE_DEPTH   = cpl_pkg::SPARSE_DEPTH_DEF,
    parameter int EXTRA_DEPTH    = cpl_pkg::EXTRA_DEPTH_DEF,
    parameter int EXT_DEPTH      = cpl_pkg::EXT_DEPTH_DEF,
    parameter int DENSE_FLAG_BIT = cpl_pkg::DENSE_FLAG_BIT_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire cpl_pkg::cpl_item_t  q_item,
    input  wire logic [7:0]          page_base,
    input  wire logic [8:0]          page_total,
    input  wire logic [12:0]         extra_used,
    input  wire logic [12:0]         ext_used,
    input  wire logic [15:0]         special_pinyin,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [15:0]              m_pinyin,
    output logic                     m_found
);

    localparam int DW = $clog2(DENSE_DEPTH);
    localparam int SW = $clog2(SPARSE_DEPTH);
    localparam int XW = (EXTRA_DEPTH > 1) ? $clog2(EXTRA_DEPTH) : 1;
    localparam int EW = (EXT_DEPTH > 1) ? $clog2(EXT_DEPTH) : 1;
    localparam int PW = 17; // search bounds, up to 65536
    localparam logic [16:0] DENSE_LIM  = 17'(DENSE_DEPTH);
    localparam logic [16:0] SPARSE_LIM = 17'(SPARSE_DEPTH);
    localparam logic [16:0] EXTRA_LIM  = 17'(EXTRA_DEPTH);
    localparam logic [16:0] EXT_LIM    = 17'(EXT_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PAGE  = 10'b0000000010,
        S_DESC  = 10'b0000000100,
        S_DENSE = 10'b0000001000,
        S_SPRB  = 10'b0000010000,
        S_SPRD  = 10'b0000100000,
        S_SPWD  = 10'b0001000000,
        S_PRSET = 10'b0010000000,
        S_PRB   = 10'b0100000000,
        S_PRD   = 10'b1000000000
    } state_t;

    // memories
    logic [15:0] desc_mem   [cpl_pkg::PAGE_DEPTH];
    logic [7:0]  runs_mem   [cpl_pkg::PAGE_DEPTH];
    logic [15:0] dense_mem  [DENSE_DEPTH];
    logic [7:0]  slow_mem   [SPARSE_DEPTH];
    logic [15:0] spy_mem    [SPARSE_DEPTH];
    logic [31:0] extra_mem  [EXTRA_DEPTH];
    logic [31:0] ext_mem    [EXT_DEPTH];

    state_t      state_reg, state_next;
    logic [20:0] point_reg;
    logic [7:0]  pidx_reg;
    logic [16:0] off_reg, cnt_reg;
    logic [16:0] lo_reg, hi_reg;
    logic        use_ext_reg;
    logic [15:0] desc_q, dense_q, spy_q;
    logic [7:0]  runs_q, slow_q;
    logic [31:0] pair_q;
    logic [15:0] res_reg;
    logic        m_valid_reg;

    logic        take, wr_item;
    logic [16:0] mid, sp_addr, pr_addr, dense_off;
    logic [15:0] desc_clean;
    logic [8:0]  page_diff;
    logic        in_win;
    logic [16:0] key;

    assign take    = q_valid && q_ready;
    assign wr_item = take && q_item.is_write;
    assign q_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_pinyin = res_reg;
    assign m_found  = (res_reg != 16'd0);

    // table writes
    always_ff @(posedge aclk) begin
        if (wr_item) begin
            case (q_item.table_id)
                cpl_pkg::TBL_OFFSETS:
                    if (q_item.table_addr < 14'(cpl_pkg::PAGE_DEPTH))
                        desc_mem[q_item.table_addr[7:0]] <= q_item.table_word[15:0];
                cpl_pkg::TBL_COUNTS:
                    if (q_item.table_addr < 14'(cpl_pkg::PAGE_DEPTH))
                        runs_mem[q_item.table_addr[7:0]] <= q_item.table_word[7:0];
                cpl_pkg::TBL_DENSE:
                    if (17'(q_item.table_addr) < DENSE_LIM)
                        dense_mem[q_item.table_addr[DW-1:0]] <= q_item.table_word[15:0];
                cpl_pkg::TBL_SPARSE_LOW:
                    if (17'(q_item.table_addr) < SPARSE_LIM)
                        slow_mem[SW'(q_item.table_addr)] <= q_item.table_word[7:0];
                cpl_pkg::TBL_SPARSE_PY:
                    if (17'(q_item.table_addr) < SPARSE_LIM)
                        spy_mem[SW'(q_item.table_addr)] <= q_item.table_word[15:0];
                cpl_pkg::TBL_EXTRA:
                    if (17'(q_item.table_addr) < EXTRA_LIM)
                        extra_mem[XW'(q_item.table_addr)] <= q_item.table_word;
                cpl_pkg::TBL_EXT:
                    if (17'(q_item.table_addr) < EXT_LIM)
                        ext_mem[EW'(q_item.table_addr)] <= q_item.table_word;
                default: ;
            endcase
        end
    end

    // address arithmetic
    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign sp_addr    = off_reg + mid;
    assign pr_addr    = mid;
    assign desc_clean = desc_q & ~(16'd1 << DENSE_FLAG_BIT);
    assign dense_off  = {1'b0, desc_clean} + {9'd0, point_reg[7:0]};
    assign page_diff  = {1'b0, point_reg[15:8]} - {1'b0, page_base};
    assign in_win     = (point_reg[15:8] >= page_base) && (page_diff < page_total);
    assign key        = {1'b0, point_reg[15:0]};

    // registered memory reads
    always_ff @(posedge aclk) begin
        desc_q  <= desc_mem[pidx_reg];
        runs_q  <= runs_mem[pidx_reg];
        dense_q <= dense_mem[dense_off[DW-1:0]];
        slow_q  <= slow_mem[sp_addr[SW-1:0]];
        spy_q   <= spy_mem[SW'(off_reg + lo_reg)];
        pair_q  <= use_ext_reg ? ext_mem[EW'(pr_addr)] : extra_mem[XW'(pr_addr)];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (take && !q_item.is_write) state_next = S_PAGE;
            S_PAGE:  state_next = S_DESC;
            S_DESC:  state_next = S_DENSE;
            S_DENSE: state_next = S_IDLE;
            S_SPRB:  state_next = S_SPRD;
            S_SPRD:  state_next = S_SPRB;
            S_SPWD:  state_next = S_IDLE;
            S_PRSET: state_next = S_PRB;
            S_PRB:   state_next = S_PRD;
            S_PRD:   state_next = S_PRB;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: if (take && !q_item.is_write) begin
                    point_reg <= q_item.codepoint;
                end
                S_PAGE: begin
                    pidx_reg <= page_diff[7:0];
                    if (point_reg[20:16] != 5'd0) begin
                        if (point_reg[20:16] == cpl_pkg::EXT_PLANE) begin
                            use_ext_reg <= 1'b1;
                            state_reg   <= S_PRSET;
                        end else begin
                            res_reg     <= (point_reg == cpl_pkg::SPECIAL_POINT)
                                           ? special_pinyin : 16'd0;
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                    end else if (!in_win) begin
                        use_ext_reg <= 1'b0;
                        state_reg   <= S_PRSET;
                    end
                end
                S_DESC: ; // descriptor read in flight
                S_DENSE: begin
                    // descriptor and run length now valid
                    if (desc_q[DENSE_FLAG_BIT]) begin
                        if (dense_off >= DENSE_LIM) begin
                            use_ext_reg <= 1'b0;
                            state_reg   <= S_PRSET;
                        end else begin
                            state_reg <= S_SPWD;
                            off_reg   <= 17'd0;
                            cnt_reg   <= 17'd1; // marks dense path
                        end
                    end else if ({1'b0, desc_q} + {9'd0, runs_q} > SPARSE_LIM) begin
                        use_ext_reg <= 1'b0;
                        state_reg   <= S_PRSET;
                    end else begin
                        off_reg   <= {1'b0, desc_q};
                        cnt_reg   <= {9'd0, runs_q};
                        lo_reg    <= 17'd0;
                        hi_reg    <= {9'd0, runs_q};
                        state_reg <= S_SPRB;
                    end
                end
                S_SPRB: begin
                    if (lo_reg >= hi_reg) begin
                        // final check reads slow at lo: mid equals lo here
                        state_reg <= S_SPWD;
                    end
                end
                S_SPRD: begin
                    if (slow_q < point_reg[7:0]) lo_reg <= mid + 17'd1;
                    else hi_reg <= mid;
                end
                S_SPWD: begin
                    // wait state so spy/slow reads at lo settle
                    state_reg <= S_PRB;
                    use_ext_reg <= 1'b0;
                    hi_reg <= 17'h1FFFF; // marker: verify step
                end
                S_PRSET: begin
                    lo_reg <= 17'd0;
                    if (use_ext_reg)
                        hi_reg <= ({4'd0, ext_used} > EXT_LIM) ? EXT_LIM : {4'd0, ext_used};
                    else
                        hi_reg <= ({4'd0, extra_used} > EXTRA_LIM)
                                  ? EXTRA_LIM : {4'd0, extra_used};
                    cnt_reg <= 17'd0;
                    off_reg <= 17'h1FFFF; // marks pair search
                end
                S_PRB: begin
                    if (hi_reg == 17'h1FFFF) begin
                        // page step verify: dense or sparse hit
                        if (cnt_reg == 17'd1 && off_reg == 17'd0 &&
                            desc_q[DENSE_FLAG_BIT]) begin
                            if (dense_q != 16'd0) begin
                                res_reg <= dense_q; m_valid_reg <= 1'b1;
                                state_reg <= S_IDLE;
                            end else state_reg <= S_PRSET;
                        end else if (lo_reg < cnt_reg && slow_q == point_reg[7:0]
                                     && spy_q != 16'd0) begin
                            res_reg <= spy_q; m_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end else state_reg <= S_PRSET;
                    end else if (lo_reg >= hi_reg) begin
                        state_reg <= S_PRD;
                        hi_reg    <= lo_reg;
                        cnt_reg   <= 17'h10000 | cnt_reg; // done flag
                    end
                end
                S_PRD: begin
                    if (cnt_reg[16]) begin
                        res_reg <= (lo_reg < {1'b0, cnt_reg[15:0]} &&
                                    {1'b0, pair_q[31:16]} == key_sel())
                                   ? pair_q[15:0] : 16'd0;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end else if ({1'b0, pair_q[31:16]} < key_sel()) begin
                        lo_reg <= mid + 17'd1;
                    end else hi_reg <= mid;
                end
                default: ;
            endcase
            // remember count at pair search start
            if (state_reg == S_PRSET) begin
                if (use_ext_reg)
                    cnt_reg <= ({4'd0, ext_used} > EXT_LIM) ? EXT_LIM : {4'd0, ext_used};
                else
                    cnt_reg <= ({4'd0, extra_used} > EXTRA_LIM)
                               ? EXTRA_LIM : {4'd0, extra_used};
            end
        end
    end

    function automatic logic [16:0] key_sel();
        return key;
    endfunction

endmodule
`default_nettype wire

/* design/codepoint_pinyin_lookup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// codepoint_pinyin_lookup
// maps a code point to a pinyin code through paged, dense and sorted tables
// ----------------------------------------------------------------------------
// a dense hit passes the page, descriptor, dense, wait and verify steps; a
// sparse run search that misses goes on to a binary search of the pair
// table; each binary-search probe waits on one memory read
// one lookup at a time: items are taken only while idle with no result pending
// reset: aresetn synchronous active low clears configuration registers, queue and sequencer;
// table memories hold no reset and must be written before use
module codepoint_pinyin_lookup #(
    parameter int DENSE_DEPTH    = cpl_pkg::DENSE_DEPTH_DEF,
    parameter int SPARSE_DEPTH   = cpl_pkg::SPARSE_DEPTH_DEF,
    parameter int EXTRA_DEPTH    = cpl_pkg::EXTRA_DEPTH_DEF,
    parameter int EXT_DEPTH      = cpl_pkg::EXT_DEPTH_DEF,
    parameter int DENSE_FLAG_BIT = cpl_pkg::DENSE_FLAG_BIT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [20:0] s_codepoint,
    input  wire logic [2:0]  s_table_id,
    input  wire logic [13:0] s_table_addr,
    input  wire logic [31:0] s_table_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_pinyin,
    output logic             m_found
);

    logic [7:0]  page_base_reg;
    logic [8:0]  page_total_reg;
    logic [12:0] extra_used_reg, ext_used_reg;
    logic [15:0] special_reg;
    logic        cfg_wr;
    cpl_pkg::cpl_item_t in_item, q_item;
    logic        q_valid, q_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_base_reg  <= '0;
            page_total_reg <= '0;
            extra_used_reg <= '0;
            ext_used_reg   <= '0;
            special_reg    <= '0;
        end else if (cfg_wr && paddr[1:0] == 2'd0) begin
            case (paddr[4:2])
                cpl_pkg::REG_PAGE_BASE:  page_base_reg  <= pwdata[7:0];
                cpl_pkg::REG_PAGE_TOTAL: page_total_reg <= pwdata[8:0];
                cpl_pkg::REG_EXTRA_USED: extra_used_reg <= pwdata[12:0];
                cpl_pkg::REG_EXT_USED:   ext_used_reg   <= pwdata[12:0];
                cpl_pkg::REG_SPECIAL:    special_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        prdata = 32'd0;
        case (paddr[4:2])
            cpl_pkg::REG_PAGE_BASE:  prdata = {24'd0, page_base_reg};
            cpl_pkg::REG_PAGE_TOTAL: prdata = {23'd0, page_total_reg};
            cpl_pkg::REG_EXTRA_USED: prdata = {19'd0, extra_used_reg};
            cpl_pkg::REG_EXT_USED:   prdata = {19'd0, ext_used_reg};
            cpl_pkg::REG_SPECIAL:    prdata = {16'd0, special_reg};
            default: prdata = 32'd0;
        endcase
    end

    assign in_item.is_write   = s_kind;
    assign in_item.table_id   = s_table_id;
    assign in_item.table_addr = s_table_addr;
    assign in_item.table_word = s_table_word;
    assign in_item.codepoint  = s_codepoint;

    cpl_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    cpl_back #(
        .DENSE_DEPTH(DENSE_DEPTH), .SPARSE_DEPTH(SPARSE_DEPTH),
        .EXTRA_DEPTH(EXTRA_DEPTH), .EXT_DEPTH(EXT_DEPTH),
        .DENSE_FLAG_BIT(DENSE_FLAG_BIT)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .page_base(page_base_reg), .page_total(page_total_reg),
        .extra_used(extra_used_reg), .ext_used(ext_used_reg),
        .special_pinyin(special_reg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pinyin(m_pinyin), .m_found(m_found)
    );

endmodule
`default_nettype wire
